/* sv/afvf_pkg.sv */
// shared widths, codes and constants of the analytic flow velocity field
package afvf_pkg;

  localparam int unsigned XY_W       = 32;          // query point and velocity words
  localparam int unsigned SQ_W       = 64;          // x^2 + y^2
  localparam int unsigned ROOT_W     = 32;          // floor(sqrt) of the radius square
  localparam int unsigned SQRT_LAT   = ROOT_W;      // one root bit per stage
  localparam int unsigned DIV_Q_W    = 48;          // quotient bits of each divider
  localparam int unsigned DIV_D_W    = 32;          // divisor and remainder bits
  localparam int unsigned DIV_LAT    = DIV_Q_W;     // one quotient bit per stage
  localparam int unsigned K_W        = 30;
  localparam int unsigned RK_W       = XY_W + K_W;  // |strength| * 1/(2 pi)
  localparam int unsigned MAG_W      = 49;          // component magnitude before saturation
  localparam int unsigned LATENCY    = 6 + SQRT_LAT + DIV_LAT;

  // round(2^32 / (2 pi))
  localparam logic [K_W-1:0] INV_TWO_PI = 30'd683565276;

  localparam logic [30:0] HALF_WIDTH_RST = 31'd65536;

  typedef enum logic [2:0] {
    MODE_NONE       = 3'd0,
    MODE_CONST      = 3'd1,
    MODE_COUETTE    = 3'd2,
    MODE_POISEUILLE = 3'd3,
    MODE_VORTEX     = 3'd4
  } flow_mode_e;

  typedef enum logic [2:0] {
    REG_FLOW_MODE   = 3'd0,
    REG_PEAK_SPEED  = 3'd1,
    REG_HALF_WIDTH  = 3'd2,
    REG_VORTEX_STR  = 3'd3,
    REG_CORE_RADIUS = 3'd4
  } cfg_reg_e;

endpackage

/* sv/analytic_flow_velocity_field.sv */
// analytic flow velocity field: each accepted start gives one result on done_o
// throughput one word per cycle, busy is never raised; depth set by the
// 32-stage square root and the 48-stage dividers in series
// results appear for exactly one cycle on done_o, the receiver cannot stall
// reset clears the valid pipeline and loads the register defaults
module analytic_flow_velocity_field import afvf_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  logic signed [XY_W-1:0] pos_x_i,
  input  logic signed [XY_W-1:0] pos_y_i,
  input  logic                   cfg_we_i,
  input  logic [2:0]             cfg_idx_i,
  input  logic [31:0]            cfg_data_i,
  output logic                   done_o,
  output logic signed [XY_W-1:0] vel_x_o,
  output logic signed [XY_W-1:0] vel_y_o
);

  // side data that travels next to the square root
  typedef struct packed {
    logic [62:0]     nabs;   // |peak_speed * y|
    logic            cneg;
    logic [XY_W-1:0] ax;
    logic [XY_W-1:0] ay;
    logic            xneg;
    logic            yneg;
    logic [RK_W-1:0] rk;
  } afvf_side1_t;

  // side data that travels next to the dividers
  typedef struct packed {
    logic        in_core;
    logic [29:0] rk_hi;
    logic        ovf;
    logic        cneg;
    logic        xneg;
    logic        yneg;
    logic        dzero;
  } afvf_side2_t;

  function automatic logic [XY_W-1:0] sat_mag(input logic neg, input logic [MAG_W-1:0] mag);
    logic [MAG_W-1:0] nmag;
    nmag = ~mag + MAG_W'(1);
    if (neg) begin
      sat_mag = (mag >= MAG_W'(64'd2147483648)) ? 32'h8000_0000 : nmag[XY_W-1:0];
    end else begin
      sat_mag = (mag > MAG_W'(64'd2147483647)) ? 32'h7fff_ffff : mag[XY_W-1:0];
    end
  endfunction

  // ---------------------------------------------------------------- registers
  logic [2:0]             flow_mode_q;
  logic signed [XY_W-1:0] peak_speed_q;
  logic [30:0]            half_width_q;
  logic signed [XY_W-1:0] vortex_str_q;
  logic [30:0]            core_radius_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flow_mode_q   <= MODE_NONE;
      peak_speed_q  <= '0;
      half_width_q  <= HALF_WIDTH_RST;
      vortex_str_q  <= '0;
      core_radius_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_FLOW_MODE:   flow_mode_q   <= cfg_data_i[2:0];
        REG_PEAK_SPEED:  peak_speed_q  <= cfg_data_i;
        REG_HALF_WIDTH:  half_width_q  <= cfg_data_i[30:0];
        REG_VORTEX_STR:  vortex_str_q  <= cfg_data_i;
        REG_CORE_RADIUS: core_radius_q <= cfg_data_i[30:0];
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  // every cycle takes a word
  assign busy = 1'b0;

  logic accept;
  assign accept = start && !busy;

  // valid bits, one per register stage
  logic [LATENCY-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[LATENCY-2:0], accept};
    end
  end

  // ---------------------------------------------------------------- stage p1
  // magnitudes, squares, couette product, strength times 1/(2 pi)
  logic [XY_W-1:0]        ax_d, ay_d, rabs;
  logic [SQ_W-1:0]        sqx_q, sqy_q;
  logic [RK_W-1:0]        rk_q;
  logic signed [SQ_W-1:0] cprod_q;
  logic [XY_W-1:0]        ax_q, ay_q;
  logic                   xneg_q, yneg_q;

  always_comb begin
    ax_d = pos_x_i[XY_W-1] ? XY_W'(-pos_x_i) : XY_W'(pos_x_i);
    ay_d = pos_y_i[XY_W-1] ? XY_W'(-pos_y_i) : XY_W'(pos_y_i);
    rabs = vortex_str_q[XY_W-1] ? XY_W'(-vortex_str_q) : XY_W'(vortex_str_q);
  end

  always_ff @(posedge clk_i) begin
    sqx_q   <= SQ_W'(ax_d) * SQ_W'(ax_d);
    sqy_q   <= SQ_W'(ay_d) * SQ_W'(ay_d);
    rk_q    <= RK_W'(rabs) * RK_W'(INV_TWO_PI);
    cprod_q <= SQ_W'(peak_speed_q) * SQ_W'(pos_y_i);
    ax_q    <= ax_d;
    ay_q    <= ay_d;
    xneg_q  <= pos_x_i[XY_W-1];
    yneg_q  <= pos_y_i[XY_W-1];
  end

  // ---------------------------------------------------------------- stage p2
  // radius square and couette magnitude
  logic [SQ_W-1:0] rad_q;
  afvf_side1_t     side_p2_q;
  logic [SQ_W-1:0] cabs;

  assign cabs = cprod_q[SQ_W-1] ? SQ_W'(-cprod_q) : SQ_W'(cprod_q);

  always_ff @(posedge clk_i) begin
    rad_q          <= sqx_q + sqy_q;
    side_p2_q.nabs <= cabs[62:0];
    side_p2_q.cneg <= cprod_q[SQ_W-1];
    side_p2_q.ax   <= ax_q;
    side_p2_q.ay   <= ay_q;
    side_p2_q.xneg <= xneg_q;
    side_p2_q.yneg <= yneg_q;
    side_p2_q.rk   <= rk_q;
  end

  // ---------------------------------------------------------------- square root
  logic [ROOT_W-1:0] root;
  afvf_side1_t       side1_q [SQRT_LAT];

  afvf_isqrt u_isqrt (
    .clk_i  (clk_i),
    .rad_i  (rad_q),
    .root_o (root)
  );

  always_ff @(posedge clk_i) begin
    side1_q[0] <= side_p2_q;
    for (int unsigned k = 1; k < SQRT_LAT; k++) begin
      side1_q[k] <= side1_q[k-1];
    end
  end

  // ---------------------------------------------------------------- stage p3
  // divider set-up: speed outside the core, both direction terms, couette
  afvf_side1_t        sd1;
  logic [30:0]        hw_eff;
  logic               c_ovf;
  logic [DIV_D_W-1:0] d_q;
  logic [DIV_D_W-1:0] ux_rem_q, uy_rem_q, c_rem_q, c_den_q;
  logic [DIV_Q_W-1:0] ux_num_q, uy_num_q, sp_num_q, c_num_q;
  afvf_side2_t        side_p3_q;

  assign sd1    = side1_q[SQRT_LAT-1];
  // a zero half width counts as one lsb
  assign hw_eff = (half_width_q == '0) ? 31'd1 : half_width_q;
  // quotient would need more than 32 bits, saturate straight away
  assign c_ovf  = (sd1.nabs[62:32] >= hw_eff);

  always_ff @(posedge clk_i) begin
    d_q               <= root;
    ux_rem_q          <= DIV_D_W'(sd1.ax[XY_W-1:18]);
    ux_num_q          <= {sd1.ax[17:0], 30'd0};
    uy_rem_q          <= DIV_D_W'(sd1.ay[XY_W-1:18]);
    uy_num_q          <= {sd1.ay[17:0], 30'd0};
    sp_num_q          <= DIV_Q_W'(sd1.rk[RK_W-1:16]);
    c_rem_q           <= c_ovf ? '0 : DIV_D_W'(sd1.nabs[62:32]);
    c_num_q           <= {sd1.nabs[31:0], 16'd0};
    c_den_q           <= DIV_D_W'(hw_eff);
    side_p3_q.in_core <= (root <= ROOT_W'(core_radius_q));
    side_p3_q.rk_hi   <= sd1.rk[RK_W-1:32];
    side_p3_q.ovf     <= c_ovf;
    side_p3_q.cneg    <= sd1.cneg;
    side_p3_q.xneg    <= sd1.xneg;
    side_p3_q.yneg    <= sd1.yneg;
    side_p3_q.dzero   <= (root == '0);
  end

  // ---------------------------------------------------------------- dividers
  logic [DIV_Q_W-1:0] q_sp, q_ux, q_uy, q_c;
  afvf_side2_t        side2_q [DIV_LAT];

  afvf_udiv u_div_speed (
    .clk_i (clk_i), .rem_i ('0), .num_i (sp_num_q), .den_i (d_q), .quo_o (q_sp)
  );

  afvf_udiv u_div_ux (
    .clk_i (clk_i), .rem_i (ux_rem_q), .num_i (ux_num_q), .den_i (d_q), .quo_o (q_ux)
  );

  afvf_udiv u_div_uy (
    .clk_i (clk_i), .rem_i (uy_rem_q), .num_i (uy_num_q), .den_i (d_q), .quo_o (q_uy)
  );

  afvf_udiv u_div_couette (
    .clk_i (clk_i), .rem_i (c_rem_q), .num_i (c_num_q), .den_i (c_den_q), .quo_o (q_c)
  );

  always_ff @(posedge clk_i) begin
    side2_q[0] <= side_p3_q;
    for (int unsigned j = 1; j < DIV_LAT; j++) begin
      side2_q[j] <= side2_q[j-1];
    end
  end

  // ---------------------------------------------------------------- stage p4
  // speed select and split products of speed and direction
  afvf_side2_t        sd2;
  logic [DIV_Q_W-1:0] spm;
  logic [62:0]        px_q, py_q;
  logic [46:0]        qx_q, qy_q;
  logic [XY_W-1:0]    cq_q;
  afvf_side2_t        side_p4_q;

  assign sd2 = side2_q[DIV_LAT-1];
  assign spm = sd2.in_core ? DIV_Q_W'(sd2.rk_hi) : q_sp;

  always_ff @(posedge clk_i) begin
    px_q      <= 63'(spm[DIV_Q_W-1:16]) * 63'(q_ux[30:0]);
    qx_q      <= 47'(spm[15:0]) * 47'(q_ux[30:0]);
    py_q      <= 63'(spm[DIV_Q_W-1:16]) * 63'(q_uy[30:0]);
    qy_q      <= 47'(spm[15:0]) * 47'(q_uy[30:0]);
    cq_q      <= q_c[DIV_Q_W-1:16];
    side_p4_q <= sd2;
  end

  // ---------------------------------------------------------------- stage p5
  // recombine the partial products, drop 30 fraction bits
  logic [47:0]      lo_x, lo_y;
  logic [MAG_W-1:0] mx_q, my_q;
  logic [XY_W-1:0]  cq2_q;
  afvf_side2_t      side_p5_q;

  assign lo_x = 48'({px_q[13:0], 16'd0}) + 48'(qx_q);
  assign lo_y = 48'({py_q[13:0], 16'd0}) + 48'(qy_q);

  always_ff @(posedge clk_i) begin
    mx_q      <= MAG_W'(px_q[62:14]) + MAG_W'(lo_x[47:30]);
    my_q      <= MAG_W'(py_q[62:14]) + MAG_W'(lo_y[47:30]);
    cq2_q     <= cq_q;
    side_p5_q <= side_p4_q;
  end

  // ---------------------------------------------------------------- output
  // sign, saturation and mode select
  logic            rneg;
  logic [XY_W-1:0] vx_d, vy_d;
  logic [XY_W-1:0] vel_x_q, vel_y_q;

  assign rneg = vortex_str_q[XY_W-1];

  always_comb begin
    vx_d = '0;
    vy_d = '0;
    unique case (flow_mode_q)
      MODE_CONST: begin
        vx_d = peak_speed_q;
      end
      MODE_COUETTE: begin
        vx_d = sat_mag(side_p5_q.cneg,
                       side_p5_q.ovf ? MAG_W'(64'h1_0000_0000) : MAG_W'(cq2_q));
      end
      MODE_VORTEX: begin
        // point at the origin gives no flow
        if (!side_p5_q.dzero) begin
          vx_d = sat_mag(rneg ^ side_p5_q.xneg, mx_q);
          vy_d = sat_mag(!(rneg ^ side_p5_q.yneg), my_q);
        end
      end
      default: ;  // none, poiseuille and unused codes give zero
    endcase
  end

  always_ff @(posedge clk_i) begin
    vel_x_q <= vx_d;
    vel_y_q <= vy_d;
  end

  assign done_o  = vld_q[LATENCY-1];
  assign vel_x_o = vel_x_q;
  assign vel_y_o = vel_y_q;

  // ---------------------------------------------------------------- assertions
  a_done_follows_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, LATENCY))
    else $error("result word without a matching start");

  a_vy_zero_off_vortex: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && flow_mode_q != MODE_VORTEX) |-> (vel_y_o == '0))
    else $error("vel_y non-zero outside vortex mode");

  a_none_mode_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && flow_mode_q == MODE_NONE) |-> (vel_x_o == '0 && vel_y_o == '0))
    else $error("non-zero velocity with no flow selected");

endmodule

/* sv/afvf_isqrt.sv */
// pipelined integer square root, one root bit per stage
module afvf_isqrt import afvf_pkg::*; (
  input  logic              clk_i,
  input  logic [SQ_W-1:0]   rad_i,
  output logic [ROOT_W-1:0] root_o
);

  localparam int unsigned REM_W = ROOT_W + 3;

  logic [REM_W-1:0]  rem_q  [SQRT_LAT];
  logic [ROOT_W-1:0] root_q [SQRT_LAT];
  logic [SQ_W-1:0]   rad_q  [SQRT_LAT];

  for (genvar k = 0; k < SQRT_LAT; k++) begin : g_stage
    logic [REM_W-1:0]  rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [SQ_W-1:0]   rad_in;
    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic              ge;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign rad_in  = rad_q[k-1];
    end

    // bring down the next two radicand bits
    assign rem_sh = {rem_in[REM_W-3:0], rad_in[SQ_W-1 -: 2]};
    assign trial  = REM_W'({root_in, 2'b01});
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk_i) begin
      rem_q[k]  <= ge ? (rem_sh - trial) : rem_sh;
      root_q[k] <= {root_in[ROOT_W-2:0], ge};
      rad_q[k]  <= {rad_in[SQ_W-3:0], 2'b00};
    end
  end

  assign root_o = root_q[SQRT_LAT-1];

endmodule

/* sv/afvf_udiv.sv */
// pipelined restoring divider, one quotient bit per stage
module afvf_udiv import afvf_pkg::*; (
  input  logic               clk_i,
  input  logic [DIV_D_W-1:0] rem_i,   // upper dividend part, below the divisor
  input  logic [DIV_Q_W-1:0] num_i,   // lower dividend part
  input  logic [DIV_D_W-1:0] den_i,
  output logic [DIV_Q_W-1:0] quo_o
);

  logic [DIV_D_W-1:0] rem_q [DIV_LAT];
  logic [DIV_Q_W-1:0] num_q [DIV_LAT];
  logic [DIV_D_W-1:0] den_q [DIV_LAT];
  logic [DIV_Q_W-1:0] quo_q [DIV_LAT];

  for (genvar j = 0; j < DIV_LAT; j++) begin : g_stage
    logic [DIV_D_W-1:0] rem_in;
    logic [DIV_Q_W-1:0] num_in;
    logic [DIV_D_W-1:0] den_in;
    logic [DIV_Q_W-1:0] quo_in;
    logic [DIV_D_W:0]   rem_sh;
    logic [DIV_D_W:0]   diff;
    logic               ge;

    if (j == 0) begin : g_first
      assign rem_in = rem_i;
      assign num_in = num_i;
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[j-1];
      assign num_in = num_q[j-1];
      assign den_in = den_q[j-1];
      assign quo_in = quo_q[j-1];
    end

    assign rem_sh = {rem_in, num_in[DIV_Q_W-1]};
    assign ge     = (rem_sh >= {1'b0, den_in});
    assign diff   = rem_sh - {1'b0, den_in};

    always_ff @(posedge clk_i) begin
      rem_q[j] <= ge ? diff[DIV_D_W-1:0] : rem_sh[DIV_D_W-1:0];
      num_q[j] <= {num_in[DIV_Q_W-2:0], 1'b0};
      den_q[j] <= den_in;
      quo_q[j] <= {quo_in[DIV_Q_W-2:0], ge};
    end
  end

  assign quo_o = quo_q[DIV_LAT-1];

endmodule
